// File: rtl/mrcm_pkg.sv
// Shared types and constants of the rate controller and rotor mixer.
package mrcm_pkg;

   // Field widths.
   localparam int RateW    = 16;
   localparam int GainW    = 16;
   localparam int ThrustW  = 16;
   localparam int SpeedW   = 16;
   localparam int ErrW     = RateW + 1;   // ref minus measured rate
   localparam int VecW     = 23;          // acceleration / thrust vector element, Q.12
   localparam int RoundBit = 2048;        // half an LSB after the 12-bit shift
   localparam int FracShift = 12;

   // Square root unit: the radicand is the mixer sum shifted down by 18 bits.
   localparam int SumShift = 18;
   localparam int RadW     = 32;
   localparam int RootW    = RadW / 2;
   localparam int RootStepsPerCycle = 2;
   localparam int RootCycles = RootW / RootStepsPerCycle;
   localparam int RemW     = RootW + 2;

   // Configuration port.
   localparam int CsrIdxW  = 2;
   localparam int CsrDataW = 16;
   localparam logic [CsrIdxW-1:0] RegGainRoll  = 2'd0;
   localparam logic [CsrIdxW-1:0] RegGainPitch = 2'd1;
   localparam logic [CsrIdxW-1:0] RegGainYaw   = 2'd2;

   localparam logic [GainW-1:0] GainRollReset  = 16'd10423;
   localparam logic [GainW-1:0] GainPitchReset = 16'd8533;
   localparam logic [GainW-1:0] GainYawReset   = 16'd1048;

   // Mixer table, 14 fraction bits, columns roll / pitch / yaw / thrust.
   localparam int OutFields  = 6;
   localparam int TableRows  = 6;
   localparam int TableIdxW  = 3;
   localparam int MixCols    = 4;
   localparam longint MixRom [TableRows][MixCols] = '{
      '{  64'sd49665718, -64'sd105066922, -64'sd1092423229, 64'sd271708126 },
      '{  64'sd99331436,            64'sd0,  64'sd1092423229, 64'sd271708126 },
      '{  64'sd49665718,  64'sd105066922, -64'sd1092423229, 64'sd271708126 },
      '{ -64'sd49665718,  64'sd105066922,  64'sd1092423229, 64'sd271708126 },
      '{ -64'sd99331436,            64'sd0, -64'sd1092423229, 64'sd271708126 },
      '{ -64'sd49665718, -64'sd105066922,  64'sd1092423229, 64'sd271708126 }
   };

   // Accumulator control from the sequencer to the multiply-accumulate unit.
   typedef struct packed {
      logic acc_en;
      logic acc_clr;
   } mac_ctrl_type;

endpackage

// File: rtl/multirotor_rate_control_mixer_top.sv
// Rate controller and rotor mixer: sequencer, operand selection and result registers.
//
// One start beat is taken while busy is low; busy then stays high until the
// result strobe. A single multiplier forms the three gain products and then,
// row by row, the four mixer products of each rotor; an iterative root unit
// that yields two bits per cycle turns each row sum into a speed. Each rotor
// passes through its four products, the accumulate, the root start, the root
// steps and the write-back, so rsp_valid is high for one cycle once the last
// rotor speed is written, and busy falls in that same cycle. The strobe cannot
// be held off: the rotor speeds are valid only while rsp_valid is high. Gains
// may be written only while busy is low.
module multirotor_rate_control_mixer_top
   import mrcm_pkg::*;
#(
   parameter int ROTORS     = 6,
   parameter int COEF_WIDTH = 32
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  logic [RateW-1:0]    req_rate_x,
   input  logic [RateW-1:0]    req_rate_y,
   input  logic [RateW-1:0]    req_rate_z,
   input  logic [RateW-1:0]    req_ref_rate_x,
   input  logic [RateW-1:0]    req_ref_rate_y,
   input  logic [RateW-1:0]    req_ref_rate_z,
   input  logic [ThrustW-1:0]  req_thrust_ref,
   output logic                rsp_valid,
   output logic [SpeedW-1:0]   rsp_rotor_speed_0,
   output logic [SpeedW-1:0]   rsp_rotor_speed_1,
   output logic [SpeedW-1:0]   rsp_rotor_speed_2,
   output logic [SpeedW-1:0]   rsp_rotor_speed_3,
   output logic [SpeedW-1:0]   rsp_rotor_speed_4,
   output logic [SpeedW-1:0]   rsp_rotor_speed_5,
   input  logic                csr_write_en,
   input  logic [CsrIdxW-1:0]  csr_index,
   input  logic [CsrDataW-1:0] csr_wdata
);

   // Table entries never exceed 32 signed bits after saturation.
   localparam int CW  = (COEF_WIDTH < 32) ? COEF_WIDTH : 32;
   localparam int AW  = (CW > ErrW) ? CW : ErrW;
   localparam int PW  = AW + VecW;
   localparam int SW  = (PW + 2 > 52) ? PW + 2 : 52;
   localparam int RW  = $clog2(ROTORS);
   localparam int SPD = (ROTORS > OutFields) ? ROTORS : OutFields;
   localparam int SIW = $clog2(SPD);

   localparam logic [2:0] StIdle   = 3'd0;
   localparam logic [2:0] StGain   = 3'd1;
   localparam logic [2:0] StRow    = 3'd2;
   localparam logic [2:0] StAdd    = 3'd3;
   localparam logic [2:0] StRootGo = 3'd4;
   localparam logic [2:0] StRoot   = 3'd5;

   logic [2:0]       state_ff, state_in;
   logic [1:0]       cnt_ff,   cnt_in;
   logic [RW-1:0]    row_ff,   row_in;
   logic             valid_ff, valid_in;
   logic             tag_gain_ff, tag_gain_in;
   logic             tag_row_ff,  tag_row_in;
   logic             tag_first_ff, tag_first_in;
   logic [1:0]       tag_idx_ff,  tag_idx_in;
   logic             big_ff,   big_in;

   logic [GainW-1:0] gain_roll_ff, gain_pitch_ff, gain_yaw_ff;

   logic signed [ErrW-1:0]  nerr_ff [3];
   logic signed [VecW-1:0]  vec_ff  [MixCols];
   logic [SpeedW-1:0]       speed_ff [SPD];

   logic                    accept;
   logic signed [AW-1:0]    mul_a;
   logic signed [VecW-1:0]  mul_b;
   logic signed [CW-1:0]    coef;
   logic [GainW-1:0]        gain_sel;
   mac_ctrl_type            mac_ctrl;
   logic signed [PW-1:0]    prod;
   logic signed [SW-1:0]    acc;
   logic signed [PW-1:0]    rnd;
   logic                    sum_pos;
   logic [RadW-1:0]         radicand;
   logic                    root_start;
   logic                    root_done;
   logic [RootW-1:0]        root;

   // Mixer coefficient, saturated to the signed COEF_WIDTH range.
   function automatic logic signed [CW-1:0] coef_at(input logic [RW-1:0] row,
                                                    input logic [1:0] col);
      longint v;
      longint cmax;
      longint cmin;
      logic [TableIdxW-1:0] ridx;
      ridx = TableIdxW'(row);
      cmax = (longint'(1) <<< (COEF_WIDTH - 1)) - 1;
      cmin = -cmax - 1;
      v    = 0;
      if (int'(ridx) < TableRows) begin
         v = MixRom[ridx][col];
      end
      if (v > cmax) begin
         v = cmax;
      end
      if (v < cmin) begin
         v = cmin;
      end
      return CW'(v);
   endfunction

   assign accept = start && !busy;

   always_comb begin
      case (cnt_ff)
         2'd0:    gain_sel = gain_roll_ff;
         2'd1:    gain_sel = gain_pitch_ff;
         default: gain_sel = gain_yaw_ff;
      endcase
   end

   assign coef = coef_at(row_ff, cnt_ff);

   always_comb begin
      if (state_ff == StGain) begin
         mul_a = AW'(nerr_ff[cnt_ff]);
         mul_b = {{(VecW-GainW){1'b0}}, gain_sel};
      end else begin
         mul_a = AW'(coef);
         mul_b = vec_ff[cnt_ff];
      end
   end

   assign mac_ctrl.acc_en  = tag_row_ff;
   assign mac_ctrl.acc_clr = tag_first_ff;

   mrcm_mac #(
      .AW (AW),
      .BW (VecW),
      .SW (SW)
   ) u_mac (
      .clock (clock),
      .reset (reset),
      .op_a  (mul_a),
      .op_b  (mul_b),
      .ctrl  (mac_ctrl),
      .prod  (prod),
      .acc   (acc)
   );

   // Round half up, then drop the 12 fraction bits of the gain.
   assign rnd = prod + PW'(RoundBit);

   assign sum_pos  = !acc[SW-1] && (acc != '0);
   assign radicand = sum_pos ? acc[SumShift+RadW-1:SumShift] : '0;
   assign root_start = (state_ff == StRootGo);

   mrcm_sqrt u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (root_start),
      .radicand (radicand),
      .done     (root_done),
      .root     (root)
   );

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      row_in       = row_ff;
      valid_in     = 1'b0;
      tag_gain_in  = 1'b0;
      tag_row_in   = 1'b0;
      tag_first_in = 1'b0;
      tag_idx_in   = cnt_ff;
      big_in       = big_ff;
      case (state_ff)
         StIdle: begin
            if (accept) begin
               state_in = StGain;
               cnt_in   = '0;
            end
         end
         StGain: begin
            tag_gain_in = 1'b1;
            if (cnt_ff == 2'd2) begin
               cnt_in   = '0;
               row_in   = '0;
               state_in = StRow;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         StRow: begin
            tag_row_in   = 1'b1;
            tag_first_in = (cnt_ff == 2'd0);
            cnt_in       = cnt_ff + 1'b1;
            if (cnt_ff == 2'(MixCols - 1)) begin
               state_in = StAdd;
            end
         end
         StAdd: begin
            state_in = StRootGo;
         end
         StRootGo: begin
            // Radicands of 2^32 and above give roots that no longer fit the speed field.
            big_in   = sum_pos && (acc[SW-2:SumShift+RadW] != '0);
            state_in = StRoot;
         end
         StRoot: begin
            if (root_done) begin
               if (row_ff == RW'(ROTORS - 1)) begin
                  state_in = StIdle;
                  valid_in = 1'b1;
               end else begin
                  row_in   = row_ff + 1'b1;
                  cnt_in   = '0;
                  state_in = StRow;
               end
            end
         end
         default: begin
            state_in = StIdle;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= StIdle;
         cnt_ff       <= '0;
         row_ff       <= '0;
         valid_ff     <= 1'b0;
         tag_gain_ff  <= 1'b0;
         tag_row_ff   <= 1'b0;
         tag_first_ff <= 1'b0;
         tag_idx_ff   <= '0;
         big_ff       <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         row_ff       <= row_in;
         valid_ff     <= valid_in;
         tag_gain_ff  <= tag_gain_in;
         tag_row_ff   <= tag_row_in;
         tag_first_ff <= tag_first_in;
         tag_idx_ff   <= tag_idx_in;
         big_ff       <= big_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gain_roll_ff  <= GainRollReset;
         gain_pitch_ff <= GainPitchReset;
         gain_yaw_ff   <= GainYawReset;
      end else if (csr_write_en) begin
         case (csr_index)
            RegGainRoll:  gain_roll_ff  <= csr_wdata;
            RegGainPitch: gain_pitch_ff <= csr_wdata;
            RegGainYaw:   gain_yaw_ff   <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Input capture (negated rate error per axis, thrust in Q.12) and gain product write-back.
   always_ff @(posedge clock) begin
      if (accept) begin
         nerr_ff[0] <= ErrW'($signed(req_ref_rate_x)) - ErrW'($signed(req_rate_x));
         nerr_ff[1] <= ErrW'($signed(req_ref_rate_y)) - ErrW'($signed(req_rate_y));
         nerr_ff[2] <= ErrW'($signed(req_ref_rate_z)) - ErrW'($signed(req_rate_z));
         vec_ff[3]  <= {{(VecW-ThrustW-4){1'b0}}, req_thrust_ref, 4'b0000};
      end
      if (tag_gain_ff) begin
         vec_ff[tag_idx_ff] <= rnd[VecW+FracShift-1:FracShift];
      end
   end

   // Speed registers: rows beyond ROTORS stay at zero from the start beat.
   always_ff @(posedge clock) begin
      for (int k = 0; k < SPD; k++) begin
         if (accept) begin
            speed_ff[k] <= '0;
         end
      end
      if (state_ff == StRoot && root_done) begin
         speed_ff[SIW'(row_ff)] <= big_ff ? {SpeedW{1'b1}} : root;
      end
   end

   assign busy      = (state_ff != StIdle);
   assign rsp_valid = valid_ff;
   assign rsp_rotor_speed_0 = speed_ff[0];
   assign rsp_rotor_speed_1 = speed_ff[1];
   assign rsp_rotor_speed_2 = speed_ff[2];
   assign rsp_rotor_speed_3 = speed_ff[3];
   assign rsp_rotor_speed_4 = speed_ff[4];
   assign rsp_rotor_speed_5 = speed_ff[5];

endmodule

// File: rtl/mrcm_mac.sv
// Shared multiplier with a registered product and an accumulator behind it.
module mrcm_mac
   import mrcm_pkg::*;
#(
   parameter int AW = 32,
   parameter int BW = 23,
   parameter int SW = 57
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic signed [AW-1:0]     op_a,
   input  logic signed [BW-1:0]     op_b,
   input  mac_ctrl_type             ctrl,
   output logic signed [AW+BW-1:0]  prod,
   output logic signed [SW-1:0]     acc
);

   localparam int PW = AW + BW;

   logic signed [PW-1:0] prod_ff;
   logic signed [PW-1:0] prod_in;
   logic signed [SW-1:0] acc_ff;
   logic signed [SW-1:0] acc_in;

   assign prod_in = op_a * op_b;

   always_comb begin
      acc_in = acc_ff;
      if (ctrl.acc_en) begin
         acc_in = (ctrl.acc_clr ? {SW{1'b0}} : acc_ff)
                  + {{(SW-PW){prod_ff[PW-1]}}, prod_ff};
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      if (reset) begin
         acc_ff <= '0;
      end else begin
         acc_ff <= acc_in;
      end
   end

   assign prod = prod_ff;
   assign acc  = acc_ff;

endmodule

// File: rtl/mrcm_sqrt.sv
// Iterative integer square root, two result bits per cycle.
module mrcm_sqrt
   import mrcm_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [RadW-1:0]   radicand,
   output logic              done,
   output logic [RootW-1:0]  root
);

   localparam int CntW = $clog2(RootCycles);

   logic [RadW-1:0]  rad_ff,  rad_in;
   logic [RemW-1:0]  rem_ff,  rem_in;
   logic [RootW-1:0] root_ff, root_in;
   logic [CntW-1:0]  cnt_ff,  cnt_in;
   logic             run_ff,  run_in;
   logic             done_ff, done_in;

   logic [RemW+1:0]  rem_w;
   logic [RemW+1:0]  trial;
   logic [RootW-1:0] q;
   logic [RadW-1:0]  rad_w;

   // Restoring digit-by-digit root: bring down two radicand bits, try 4q+1.
   always_comb begin
      rem_w = {2'b00, rem_ff};
      q     = root_ff;
      rad_w = rad_ff;
      trial = '0;
      for (int j = 0; j < RootStepsPerCycle; j++) begin
         rem_w = {rem_w[RemW-1:0], rad_w[RadW-1 -: 2]};
         rad_w = {rad_w[RadW-3:0], 2'b00};
         trial = {2'b00, q, 2'b01};
         if (rem_w >= trial) begin
            rem_w = rem_w - trial;
            q     = {q[RootW-2:0], 1'b1};
         end else begin
            q     = {q[RootW-2:0], 1'b0};
         end
      end
   end

   always_comb begin
      rad_in  = rad_ff;
      rem_in  = rem_ff;
      root_in = root_ff;
      cnt_in  = cnt_ff;
      run_in  = run_ff;
      done_in = 1'b0;
      if (start) begin
         rad_in  = radicand;
         rem_in  = '0;
         root_in = '0;
         cnt_in  = '0;
         run_in  = 1'b1;
      end else if (run_ff) begin
         rad_in  = rad_w;
         rem_in  = rem_w[RemW-1:0];
         root_in = q;
         cnt_in  = cnt_ff + 1'b1;
         if (cnt_ff == CntW'(RootCycles - 1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rad_ff  <= rad_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
      if (reset) begin
         cnt_ff  <= '0;
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         run_ff  <= run_in;
         done_ff <= done_in;
      end
   end

   assign done = done_ff;
   assign root = root_ff;

endmodule
